// File: hw/rtl/sva_pkg.sv
// ----------------------------------------------------------------------------
// Sparse vector accumulator package
// Shared types, function codes and Q32.32 limits.
// ----------------------------------------------------------------------------
package sva_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned AddrW    = 6;
  localparam int unsigned CountW   = 7;
  localparam int unsigned KeyW     = 31;
  localparam int unsigned ValW     = 64;

  localparam logic [ValW-1:0] QMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ValW-1:0] QMin = 64'h8000_0000_0000_0000;

  typedef enum logic [3:0] {
    FnAcc    = 4'd0,
    FnLookup = 4'd1,
    FnClear  = 4'd2,
    FnMul    = 4'd3,
    FnDiv    = 4'd4,
    FnAdd    = 4'd5,
    FnSub    = 4'd6,
    FnRevSub = 4'd7,
    FnRevDiv = 4'd8,
    FnDump   = 4'd9
  } func_e;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StFull = 2'd1,
    StDivZ = 2'd2,
    StSat  = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic             latch;     // capture input item
    logic             rd;        // read entry at addr
    logic [AddrW-1:0] addr;
    logic             wr_val;    // write val_mem[addr] from alu result
    logic             append;    // write new pair at addr
    logic             alu_start; // start op on read value
    logic             clear_sat;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic key_match;  // registered key == stored key
    logic alu_done;
  } dp_stat_t;

endpackage

// File: hw/rtl/sva_alu.sv
// ----------------------------------------------------------------------------
// Sparse vector accumulator arithmetic unit
// Saturating Q32.32 add, sub, multiply (four 32x32 partial products over
// cycles) and restoring divide (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module sva_alu (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [3:0]                func_i,
  input  logic [sva_pkg::ValW-1:0]  v_i,
  input  logic [sva_pkg::ValW-1:0]  s_i,
  output logic                      done_o,
  output logic [sva_pkg::ValW-1:0]  res_o,
  output logic                      sat_o,
  output logic                      dz_o
);

  typedef enum logic [2:0] {
    AIdle, AMul, AMulFin, ADiv, ADivFin, ADone
  } alu_state_e;

  alu_state_e         state_q;
  logic [63:0]        a_q, b_q;
  logic               neg_q;
  logic [2:0]         pp_q;
  logic [127:0]       acc_q;
  logic [63:0]        rem_q;
  logic [127:0]       num_q;
  logic [63:0]        quo_q;
  logic               qh_q;
  logic [6:0]         cnt_q;
  logic [63:0]        res_q;
  logic               sat_q, dz_q;

  logic [63:0] v_s, s_s, r_add, r_sub, mag_a, mag_b, x_m, y_m, num_src, den_src;
  logic        ovf_add, ovf_sub;
  logic [31:0] pa, pb;
  logic [63:0] prod;
  logic [64:0] rem_sh;
  logic [63:0] mag_fin;
  logic        big_fin;

  function automatic logic [63:0] mag(input logic [63:0] x);
    mag = x[63] ? (~x + 64'd1) : x;
  endfunction

  assign v_s = v_i;
  assign s_s = s_i;
  assign r_add = v_s + s_s;
  assign ovf_add = ((v_s ^ r_add) & (s_s ^ r_add)) >> 63 != 64'd0;

  always_comb begin
    if (func_i == sva_pkg::FnRevSub) begin
      r_sub   = s_s - v_s;
      ovf_sub = (((s_s ^ v_s) & (s_s ^ r_sub)) >> 63) != 64'd0;
    end else begin
      r_sub   = v_s - s_s;
      ovf_sub = (((v_s ^ s_s) & (v_s ^ r_sub)) >> 63) != 64'd0;
    end
  end

  assign x_m = mag(v_s);
  assign y_m = mag(s_s);
  assign num_src = (func_i == sva_pkg::FnRevDiv) ? s_s : v_s;
  assign den_src = (func_i == sva_pkg::FnRevDiv) ? v_s : s_s;
  assign mag_a = mag(num_src);
  assign mag_b = mag(den_src);

  always_comb begin
    unique case (pp_q[1:0])
      2'd0:    begin pa = a_q[31:0];  pb = b_q[31:0];  end
      2'd1:    begin pa = a_q[31:0];  pb = b_q[63:32]; end
      2'd2:    begin pa = a_q[63:32]; pb = b_q[31:0];  end
      default: begin pa = a_q[63:32]; pb = b_q[63:32]; end
    endcase
  end
  assign prod = 64'(pa) * 64'(pb);

  assign rem_sh = {rem_q, num_q[127]};

  always_comb begin
    if (state_q == AMulFin) begin
      big_fin = acc_q[127:96] != 32'd0;
      mag_fin = acc_q[95:32];
    end else begin
      big_fin = qh_q;
      mag_fin = quo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AIdle;
    end else begin
      unique case (state_q)
        AIdle: if (start_i) begin
          sat_q <= 1'b0;
          dz_q  <= 1'b0;
          unique case (func_i)
            sva_pkg::FnAcc, sva_pkg::FnAdd: begin
              res_q <= ovf_add ? (v_s[63] ? sva_pkg::QMin : sva_pkg::QMax) : r_add;
              sat_q <= ovf_add;
              state_q <= ADone;
            end
            sva_pkg::FnSub, sva_pkg::FnRevSub: begin
              res_q <= ovf_sub ? ((func_i == sva_pkg::FnRevSub ? s_s[63] : v_s[63])
                                  ? sva_pkg::QMin : sva_pkg::QMax) : r_sub;
              sat_q <= ovf_sub;
              state_q <= ADone;
            end
            sva_pkg::FnMul: begin
              a_q <= x_m; b_q <= y_m; neg_q <= v_s[63] ^ s_s[63];
              pp_q <= 3'd0; acc_q <= '0;
              state_q <= AMul;
            end
            sva_pkg::FnDiv, sva_pkg::FnRevDiv: begin
              if (den_src == 64'd0) begin
                res_q <= v_s; dz_q <= 1'b1; state_q <= ADone;
              end else begin
                b_q <= mag_b; neg_q <= num_src[63] ^ den_src[63];
                num_q <= {32'd0, mag_a, 32'd0};
                rem_q <= '0; quo_q <= '0; qh_q <= 1'b0; cnt_q <= '0;
                state_q <= ADiv;
              end
            end
            default: begin
              res_q <= v_s; state_q <= ADone;
            end
          endcase
        end
        AMul: begin
          unique case (pp_q[1:0])
            2'd0:    acc_q <= acc_q + {64'd0, prod};
            2'd1,
            2'd2:    acc_q <= acc_q + {32'd0, prod, 32'd0};
            default: acc_q <= acc_q + {prod, 64'd0};
          endcase
          pp_q <= pp_q + 3'd1;
          if (pp_q[1:0] == 2'd3) state_q <= AMulFin;
        end
        ADiv: begin
          num_q <= {num_q[126:0], 1'b0};
          qh_q  <= qh_q | quo_q[63];
          if (rem_q[63] || rem_sh[63:0] >= b_q) begin
            rem_q <= rem_sh[63:0] - b_q;
            quo_q <= {quo_q[62:0], 1'b1};
          end else begin
            rem_q <= rem_sh[63:0];
            quo_q <= {quo_q[62:0], 1'b0};
          end
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd127) state_q <= ADivFin;
        end
        AMulFin, ADivFin: begin
          if (big_fin) begin
            sat_q <= 1'b1;
            res_q <= neg_q ? sva_pkg::QMin : sva_pkg::QMax;
          end else if (!neg_q) begin
            sat_q <= mag_fin[63];
            res_q <= mag_fin[63] ? sva_pkg::QMax : mag_fin;
          end else begin
            sat_q <= mag_fin > sva_pkg::QMin;
            res_q <= (mag_fin > sva_pkg::QMin) ? sva_pkg::QMin : (~mag_fin + 64'd1);
          end
          state_q <= ADone;
        end
        default: state_q <= AIdle;
      endcase
    end
  end

  assign done_o = state_q == ADone;
  assign res_o  = res_q;
  assign sat_o  = sat_q;
  assign dz_o   = dz_q;

endmodule

// File: hw/rtl/sva_datapath.sv
// ----------------------------------------------------------------------------
// Sparse vector accumulator datapath
// Key and value memories, input item registers and the arithmetic unit.
// ----------------------------------------------------------------------------
module sva_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sva_pkg::dp_cmd_t            cmd_i,
  output sva_pkg::dp_stat_t           stat_o,
  input  logic [3:0]                  func_i,
  input  logic [sva_pkg::KeyW-1:0]    key_i,
  input  logic [sva_pkg::ValW-1:0]    val_i,
  output logic [3:0]                  func_o,
  output logic [sva_pkg::KeyW-1:0]    key_o,
  output logic [sva_pkg::KeyW-1:0]    rd_key_o,
  output logic [sva_pkg::ValW-1:0]    rd_val_o,
  output logic [sva_pkg::ValW-1:0]    scalar_o,
  output logic [sva_pkg::ValW-1:0]    alu_res_o,
  output logic                        sat_o,
  output logic                        dz_o
);

  logic [sva_pkg::KeyW-1:0] key_mem [sva_pkg::Capacity];
  logic [sva_pkg::ValW-1:0] val_mem [sva_pkg::Capacity];

  logic [3:0]               func_q;
  logic [sva_pkg::KeyW-1:0] key_q, rd_key_q;
  logic [sva_pkg::ValW-1:0] s_q, rd_val_q;
  logic                     sat_q, dz_q;
  logic                     alu_done, alu_sat, alu_dz;
  logic [sva_pkg::ValW-1:0] alu_res;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= func_i;
      key_q  <= key_i;
      s_q    <= val_i;
    end
    if (cmd_i.rd) begin
      rd_key_q <= key_mem[cmd_i.addr];
      rd_val_q <= val_mem[cmd_i.addr];
    end
    if (cmd_i.append) begin
      key_mem[cmd_i.addr] <= key_q;
      val_mem[cmd_i.addr] <= s_q;
    end else if (cmd_i.wr_val) begin
      val_mem[cmd_i.addr] <= alu_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
      dz_q  <= 1'b0;
    end else if (cmd_i.clear_sat) begin
      sat_q <= 1'b0;
      dz_q  <= 1'b0;
    end else if (cmd_i.wr_val) begin
      sat_q <= sat_q | alu_sat;
      dz_q  <= dz_q | alu_dz;
    end
  end

  sva_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.alu_start),
    .func_i  (func_q),
    .v_i     (rd_val_q),
    .s_i     (s_q),
    .done_o  (alu_done),
    .res_o   (alu_res),
    .sat_o   (alu_sat),
    .dz_o    (alu_dz)
  );

  assign stat_o.key_match = rd_key_q == key_q;
  assign stat_o.alu_done  = alu_done;
  assign func_o    = func_q;
  assign key_o     = key_q;
  assign rd_key_o  = rd_key_q;
  assign rd_val_o  = rd_val_q;
  assign scalar_o  = s_q;
  assign alu_res_o = alu_res;
  assign sat_o     = sat_q;
  assign dz_o      = dz_q;

endmodule

// File: hw/rtl/sva_ctrl.sv
// ----------------------------------------------------------------------------
// Sparse vector accumulator controller
// Sequences search, update, sweep and dump; owns fill count and result reg.
// ----------------------------------------------------------------------------
module sva_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sva_pkg::dp_cmd_t              cmd_o,
  input  sva_pkg::dp_stat_t             stat_i,
  input  logic [3:0]                    func_q_i,
  input  logic [sva_pkg::KeyW-1:0]      key_i,
  input  logic [sva_pkg::KeyW-1:0]      rd_key_i,
  input  logic [sva_pkg::ValW-1:0]      rd_val_i,
  input  logic [sva_pkg::ValW-1:0]      scalar_i,
  input  logic [sva_pkg::ValW-1:0]      alu_res_i,
  input  logic                          sat_i,
  input  logic                          dz_i,
  output logic [sva_pkg::KeyW-1:0]      out_index_o,
  output logic [sva_pkg::ValW-1:0]      out_value_o,
  output logic                          found_o,
  output logic [sva_pkg::CountW-1:0]    entry_count_o,
  output logic [1:0]                    status_o,
  output logic                          last_o
);

  typedef enum logic [3:0] {
    SIdle, SDecode, SRead, SCheck, SAccWait, SSweepRead, SSweepAlu,
    SSweepWait, SDumpRead, SDumpEmit, SOut
  } state_e;

  state_e                     state_q;
  logic [sva_pkg::CountW-1:0] fill_q, ptr_q;
  logic                       ovalid_q;
  logic [sva_pkg::KeyW-1:0]   oidx_q;
  logic [sva_pkg::ValW-1:0]   oval_q;
  logic                       ofound_q, olast_q;
  logic [1:0]                 ost_q;
  logic                       accept, take;

  assign accept = in_valid && !in_stall;
  assign take   = ovalid_q && !out_stall;
  // the result register is shared, so a new item waits until it is empty
  assign in_stall = state_q != SIdle || ovalid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.latch = accept;
    cmd_o.addr  = ptr_q[sva_pkg::AddrW-1:0];
    cmd_o.clear_sat = accept;
    unique case (state_q)
      SRead, SSweepRead, SDumpRead: cmd_o.rd = 1'b1;
      SCheck: begin
        cmd_o.alu_start = fill_q != '0 && stat_i.key_match &&
                          func_q_i == sva_pkg::FnAcc;
        cmd_o.append = !(fill_q != '0 && stat_i.key_match) && ptr_q + 7'd1 >= fill_q &&
                       func_q_i == sva_pkg::FnAcc && fill_q < 7'(sva_pkg::Capacity);
        if (cmd_o.append) cmd_o.addr = fill_q[sva_pkg::AddrW-1:0];
      end
      SSweepAlu: cmd_o.alu_start = 1'b1;
      SAccWait, SSweepWait: cmd_o.wr_val = stat_i.alu_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      fill_q   <= '0;
      ptr_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (take) ovalid_q <= 1'b0;
      unique case (state_q)
        SIdle: if (accept) state_q <= SDecode;
        SDecode: begin
          ptr_q    <= '0;
          oidx_q   <= key_i;
          oval_q   <= '0;
          ofound_q <= 1'b0;
          ost_q    <= sva_pkg::StOk;
          olast_q  <= 1'b1;
          unique case (func_q_i)
            sva_pkg::FnAcc, sva_pkg::FnLookup: begin
              if (fill_q == '0) begin
                if (func_q_i == sva_pkg::FnAcc) begin
                  state_q <= SCheck; // appends via empty path below
                end else begin
                  state_q <= SOut;
                end
              end else begin
                state_q <= SRead;
              end
            end
            sva_pkg::FnClear: begin
              fill_q  <= '0;
              state_q <= SOut;
            end
            sva_pkg::FnMul, sva_pkg::FnDiv, sva_pkg::FnAdd, sva_pkg::FnSub,
            sva_pkg::FnRevSub, sva_pkg::FnRevDiv:
              state_q <= (fill_q == '0) ? SOut : SSweepRead;
            sva_pkg::FnDump:
              state_q <= (fill_q == '0) ? SOut : SDumpRead;
            default: state_q <= SOut;
          endcase
        end
        SRead: state_q <= SCheck;
        SCheck: begin
          if (fill_q != '0 && stat_i.key_match) begin
            if (func_q_i == sva_pkg::FnAcc) begin
              state_q <= SAccWait;
            end else begin
              oval_q   <= rd_val_i;
              ofound_q <= 1'b1;
              state_q  <= SOut;
            end
          end else if (fill_q != '0 && ptr_q + 7'd1 < fill_q) begin
            ptr_q   <= ptr_q + 7'd1;
            state_q <= SRead;
          end else begin
            if (func_q_i == sva_pkg::FnAcc) begin
              if (fill_q < 7'(sva_pkg::Capacity)) begin
                oval_q <= scalar_i;
                fill_q <= fill_q + 7'd1;
              end else begin
                ost_q <= sva_pkg::StFull;
              end
            end
            state_q <= SOut;
          end
        end
        SAccWait: if (stat_i.alu_done) begin
          oval_q   <= alu_res_i;
          ofound_q <= 1'b1;
          state_q  <= SOut;
        end
        SSweepRead: state_q <= SSweepAlu;
        SSweepAlu:  state_q <= SSweepWait;
        SSweepWait: if (stat_i.alu_done) begin
          if (ptr_q + 7'd1 < fill_q) begin
            ptr_q   <= ptr_q + 7'd1;
            state_q <= SSweepRead;
          end else begin
            state_q <= SOut;
          end
        end
        SDumpRead: if (!ovalid_q || take) state_q <= SDumpEmit;
        SDumpEmit: begin
          ovalid_q <= 1'b1;
          oidx_q   <= rd_key_i;
          oval_q   <= rd_val_i;
          ofound_q <= 1'b1;
          ost_q    <= sva_pkg::StOk;
          olast_q  <= ptr_q + 7'd1 == fill_q;
          ptr_q    <= ptr_q + 7'd1;
          state_q  <= (ptr_q + 7'd1 == fill_q) ? SIdle : SDumpRead;
        end
        SOut: if (!ovalid_q || take) begin
          ovalid_q <= 1'b1;
          if (state_q == SOut && func_q_i != sva_pkg::FnAcc) begin
            if (dz_i) ost_q <= sva_pkg::StDivZ;
            else if (sat_i) ost_q <= sva_pkg::StSat;
          end else if (sat_i) begin
            ost_q <= sva_pkg::StSat;
          end
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign out_valid     = ovalid_q;
  assign out_index_o   = oidx_q;
  assign out_value_o   = oval_q;
  assign found_o       = ofound_q;
  assign entry_count_o = fill_q;
  assign status_o      = ost_q;
  assign last_o        = olast_q;

endmodule

// File: hw/rtl/sparse_vector_accumulator_unit.sv
// ----------------------------------------------------------------------------
// Sparse vector accumulator
// Table of up to 64 (index, Q32.32 value) pairs with linear search.
// ----------------------------------------------------------------------------
// One item at a time; a new item is taken only once the previous result item
// has been taken. Accumulate and lookup read and compare the stored pairs
// one by one; a scalar sweep reads each entry, runs the arithmetic unit on
// it and writes the result back, with divide at one quotient bit per cycle
// in the shared divider. Dump emits one pair per previous output taken.
module sparse_vector_accumulator_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [3:0]                 func_i,
  input  logic [30:0]                key_index_i,
  input  logic signed [63:0]         operand_value_i,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [30:0]                out_index_o,
  output logic signed [63:0]         out_value_o,
  output logic                       found_o,
  output logic [6:0]                 entry_count_o,
  output logic [1:0]                 status_o,
  output logic                       last_o
);

  sva_pkg::dp_cmd_t             cmd;
  sva_pkg::dp_stat_t            stat;
  logic [3:0]                   func_q;
  logic [sva_pkg::KeyW-1:0]     key_q, rd_key;
  logic [sva_pkg::ValW-1:0]     rd_val, scalar, alu_res, oval;
  logic                         sat, dz;

  sva_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .func_i    (func_i),
    .key_i     (key_index_i),
    .val_i     (operand_value_i),
    .func_o    (func_q),
    .key_o     (key_q),
    .rd_key_o  (rd_key),
    .rd_val_o  (rd_val),
    .scalar_o  (scalar),
    .alu_res_o (alu_res),
    .sat_o     (sat),
    .dz_o      (dz)
  );

  sva_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cmd_o         (cmd),
    .stat_i        (stat),
    .func_q_i      (func_q),
    .key_i         (key_q),
    .rd_key_i      (rd_key),
    .rd_val_i      (rd_val),
    .scalar_i      (scalar),
    .alu_res_i     (alu_res),
    .sat_i         (sat),
    .dz_i          (dz),
    .out_index_o   (out_index_o),
    .out_value_o   (oval),
    .found_o       (found_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  assign out_value_o = oval;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_o <= 7'(sva_pkg::Capacity))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_o != $past(entry_count_o) |->
      (entry_count_o == $past(entry_count_o) + 7'd1 || entry_count_o == 7'd0))
    else $error("entry count changed by other than append or clear");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while busy");

endmodule
